[design/ffa_pkg.sv]
// Shared constants, types and status codes for the first-fit allocator.
package ffa_pkg;

  // Address and size width of the heap, fixed by the request and result fields.
  localparam int AW = 16;
  // Width of the heap limit register.
  localparam int LW = 17;

  // Defaults for the top-level parameters.
  localparam int MAX_SEG_DEF  = 64;
  localparam int HDR_DEF      = 24;
  localparam int INIT_DEF     = 1024;
  localparam logic [LW-1:0] LIMIT_RESET = 17'h10000;

  // Request actions.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  // One segment table entry.
  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] size;
    logic          free;
  } ffa_ent_t;

endpackage

[design/ffa_chan_if.sv]
// Valid/ready channels for requests, results and the configuration write.
interface ffa_req_if;
  import ffa_pkg::*;
  logic          valid;
  logic          ready;
  logic          action;
  logic [15:0]   size;
  logic [15:0]   address;
  modport source (output valid, output action, output size, output address, input ready);
  modport sink   (input valid, input action, input size, input address, output ready);
endinterface

interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_addr;
  logic [1:0]  status;
  modport source (output valid, output payload_addr, output status, input ready);
  modport sink   (input valid, input payload_addr, input status, output ready);
endinterface

interface ffa_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] heap_limit;
  modport source (output valid, output heap_limit, input ready);
  modport sink   (input valid, input heap_limit, output ready);
endinterface

[design/ffa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/first_fit_allocator_core.sv]
// First-fit heap allocator with an address-ordered segment table in RAM.
//
//  channel | dir | beat payload                      | accepted when
//  in_ch   | in  | action, size, address             | valid && ready
//  out_ch  | out | payload_addr, status              | valid && ready
//  cfg_ch  | in  | heap_limit                        | valid (ready always high)
//
// A request scans the table one entry at a time, moves the tail entries up when a
// split opens a slot, and for a free also makes a coalescing pass over the table,
// since the single table RAM gives one registered read per cycle.
// in_ch.ready is high only in idle.
// Reset is synchronous; the table needs no clearing pass: entry 0 reads as the
// initial free segment until it is first written. A stalled result holds the
// sequencer until out_ch takes the beat.
module first_fit_allocator_core import ffa_pkg::*; #(
  parameter int MAX_SEGMENTS  = MAX_SEG_DEF,
  parameter int HEADER_BYTES  = HDR_DEF,
  parameter int INITIAL_BYTES = INIT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ffa_req_if.sink   in_ch,
  ffa_rsp_if.source out_ch,
  ffa_cfg_if.sink   cfg_ch
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = $bits(ffa_ent_t);
  localparam logic [AW+1:0] HDR  = (AW+2)'(HEADER_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);
  localparam logic [AW+1:0] SPAN = (AW+2)'(1) << AW;
  localparam ffa_ent_t RESET_ENT = '{start: '0,
                                     size: AW'(INITIAL_BYTES - HEADER_BYTES),
                                     free: 1'b1};

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SH_RD, S_SH_WR, S_SPLIT_WR, S_ALLOC_WR,
    S_APPEND, S_CO_LOAD, S_CO_TAKE, S_CO_RD, S_CO_CMP, S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic          act_r, act_nxt;
  logic [AW-1:0] req_r, req_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [LW-1:0] bp_r, bp_nxt;
  logic [LW-1:0] limit_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic [IW-1:0] f_r, f_nxt;
  logic          split_r, split_nxt;
  ffa_ent_t      ent_r, ent_nxt;
  ffa_ent_t      cur_r, cur_nxt;
  logic [AW-1:0] res_addr_r, res_addr_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] out_addr_r, out_addr_nxt;
  logic [1:0]    out_st_r, out_st_nxt;
  logic          e0_valid_r;
  logic          rd_zero_r;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  ffa_ent_t      ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  ffa_ent_t      rd_ent;
  ffa_ent_t      rd_mark;
  logic [AW+1:0] lim;
  logic [AW+1:0] app_end;

  ffa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entry 0 reads as the initial segment until it is written.
  assign rd_ent = (rd_zero_r && !e0_valid_r) ? RESET_ENT : ffa_ent_t'(ram_rdata);

  // During the coalescing pass the entry being freed reads as free.
  always_comb begin
    rd_mark = rd_ent;
    if (j_r[IW-1:0] == f_r) begin
      rd_mark.free = 1'b1;
    end
  end

  // Heap limit saturated to the address span, and the end of an appended block.
  assign lim     = ({1'b0, limit_r} > SPAN) ? SPAN : {1'b0, limit_r};
  assign app_end = {1'b0, bp_r} + HDR + {2'b00, req_r};

  assign in_ch.ready       = (state_r == S_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.payload_addr = out_addr_r;
  assign out_ch.status       = out_st_r;

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    req_nxt       = req_r;
    addr_nxt      = addr_r;
    count_nxt     = count_r;
    bp_nxt        = bp_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    w_nxt         = w_r;
    f_nxt         = f_r;
    split_nxt     = split_r;
    ent_nxt       = ent_r;
    cur_nxt       = cur_r;
    res_addr_nxt  = res_addr_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_addr_nxt  = out_addr_r;
    out_st_nxt    = out_st_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          act_nxt   = in_ch.action;
          req_nxt   = in_ch.size;
          addr_nxt  = in_ch.address;
          idx_nxt   = '0;
          state_nxt = S_SCAN_RD;
        end
      end
      // First-fit or address scan, one entry at a time.
      S_SCAN_RD: begin
        if (idx_r == count_r) begin
          if (act_r == ACT_FREE) begin
            res_addr_nxt = '0;
            res_st_nxt   = ST_UNKNOWN;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_APPEND;
          end
        end else begin
          ram_raddr = idx_r[IW-1:0];
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        f_nxt   = idx_r[IW-1:0];
        ent_nxt = rd_ent;
        if (act_r == ACT_FREE) begin
          if ({2'b00, rd_ent.start} + HDR == {2'b00, addr_r}) begin
            j_nxt     = '0;
            w_nxt     = '0;
            state_nxt = S_CO_LOAD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_SCAN_RD;
          end
        end else if (rd_ent.free && rd_ent.size >= req_r) begin
          split_nxt = ({2'b00, rd_ent.size} > {2'b00, req_r} + HDR) && (count_r < MAXC);
          k_nxt     = count_r;
          state_nxt = (({2'b00, rd_ent.size} > {2'b00, req_r} + HDR) && (count_r < MAXC))
                      ? S_SH_RD : S_ALLOC_WR;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      // Open a slot after the chosen entry by moving the tail up by one.
      S_SH_RD: begin
        if (k_r == CW'(f_r) + 1'b1) begin
          state_nxt = S_SPLIT_WR;
        end else begin
          ram_raddr = IW'(k_r - 1'b1);
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[IW-1:0];
        ram_wdata = rd_ent;
        k_nxt     = k_r - 1'b1;
        state_nxt = S_SH_RD;
      end
      S_SPLIT_WR: begin
        ram_we          = 1'b1;
        ram_waddr       = f_r + 1'b1;
        ram_wdata.start = AW'({2'b00, ent_r.start} + HDR + {2'b00, req_r});
        ram_wdata.size  = AW'({2'b00, ent_r.size} - {2'b00, req_r} - HDR);
        ram_wdata.free  = 1'b1;
        count_nxt       = count_r + 1'b1;
        state_nxt       = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        ram_we          = 1'b1;
        ram_waddr       = f_r;
        ram_wdata.start = ent_r.start;
        ram_wdata.size  = split_r ? req_r : ent_r.size;
        ram_wdata.free  = 1'b0;
        res_addr_nxt    = AW'({2'b00, ent_r.start} + HDR);
        res_st_nxt      = ST_OK;
        state_nxt       = S_DONE;
      end
      // Nothing fits: grow the heap at the break pointer, or report no memory when the table or limit is full.
      S_APPEND: begin
        if (count_r >= MAXC || app_end > lim || {1'b0, bp_r} + HDR >= SPAN) begin
          res_addr_nxt = '0;
          res_st_nxt   = ST_NOMEM;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = count_r[IW-1:0];
          ram_wdata.start = bp_r[AW-1:0];
          ram_wdata.size  = req_r;
          ram_wdata.free  = 1'b0;
          count_nxt       = count_r + 1'b1;
          bp_nxt          = app_end[LW-1:0];
          res_addr_nxt    = AW'({1'b0, bp_r} + HDR);
          res_st_nxt      = ST_OK;
        end
        state_nxt = S_DONE;
      end
      // Coalescing pass, compacting the table in place from left to right.
      S_CO_LOAD: begin
        if (j_r == count_r) begin
          count_nxt    = w_r;
          res_addr_nxt = '0;
          res_st_nxt   = ST_OK;
          state_nxt    = S_DONE;
        end else begin
          ram_raddr = j_r[IW-1:0];
          state_nxt = S_CO_TAKE;
        end
      end
      S_CO_TAKE: begin
        cur_nxt   = rd_mark;
        j_nxt     = j_r + 1'b1;
        state_nxt = S_CO_RD;
      end
      S_CO_RD: begin
        if (j_r == count_r) begin
          ram_we       = 1'b1;
          ram_waddr    = w_r[IW-1:0];
          ram_wdata    = cur_r;
          count_nxt    = w_r + 1'b1;
          res_addr_nxt = '0;
          res_st_nxt   = ST_OK;
          state_nxt    = S_DONE;
        end else begin
          ram_raddr = j_r[IW-1:0];
          state_nxt = S_CO_CMP;
        end
      end
      S_CO_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = w_r[IW-1:0];
        w_nxt     = w_r + 1'b1;
        j_nxt     = j_r + 1'b1;
        if (cur_r.free && rd_mark.free &&
            ({2'b00, cur_r.start} + HDR + {2'b00, cur_r.size} == {2'b00, rd_mark.start})) begin
          ram_wdata.start = cur_r.start;
          ram_wdata.size  = AW'({2'b00, cur_r.size} + {2'b00, rd_mark.size} + HDR);
          ram_wdata.free  = 1'b1;
          state_nxt       = S_CO_LOAD;
        end else begin
          ram_wdata = cur_r;
          cur_nxt   = rd_mark;
          state_nxt = S_CO_RD;
        end
      end
      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, control and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CW'(1);
      bp_r        <= LW'(INITIAL_BYTES);
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
      e0_valid_r  <= 1'b0;
      rd_zero_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      bp_r        <= bp_nxt;
      out_valid_r <= out_valid_nxt;
      rd_zero_r   <= (ram_raddr == '0);
      if (ram_we && ram_waddr == '0) begin
        e0_valid_r <= 1'b1;
      end
      if (cfg_ch.valid) begin
        limit_r <= cfg_ch.heap_limit;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    req_r      <= req_nxt;
    addr_r     <= addr_nxt;
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    w_r        <= w_nxt;
    f_r        <= f_nxt;
    split_r    <= split_nxt;
    ent_r      <= ent_nxt;
    cur_r      <= cur_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    out_addr_r <= out_addr_nxt;
    out_st_r   <= out_st_nxt;
  end

  // The table always holds between one and MAX_SEGMENTS entries.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 && count_r <= MAXC)
    else $error("segment count out of range");

  // The break pointer never moves down.
  a_bp_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 bp_r >= $past(bp_r))
    else $error("break pointer decreased");

  // A failed request never hands out an address.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r != ST_OK |-> out_addr_r == '0)
    else $error("address on failed request");

  // An accepted request keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while busy");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the first-fit allocator core, with a built-in predictor.
module tb_top;
  import ffa_pkg::*;

  localparam int NSEG = 64;
  localparam int HDR  = 24;
  localparam int INIT = 1024;
  localparam int RAND_PER_PHASE = 235;

  // One row of the directed stimulus table.
  typedef struct {
    logic          action;
    logic [15:0]   size;
    logic [15:0]   address;
    bit            typed;
    logic [15:0]   want_addr;
    logic [1:0]    want_status;
  } req_row_t;

  // One expected result beat.
  typedef struct {
    logic [15:0] payload_addr;
    logic [1:0]  status;
  } rsp_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ffa_req_if in_ch ();
  ffa_rsp_if out_ch ();
  ffa_cfg_if cfg_ch ();

  first_fit_allocator_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the segment table and heap state.
  logic [15:0] shd_start [NSEG];
  logic [15:0] shd_size  [NSEG];
  logic        shd_free  [NSEG];
  int          shd_count;
  logic [16:0] shd_break;
  logic [16:0] shd_limit;

  rsp_beat_t   pending_rsp[$];
  logic [15:0] live_addrs[$];
  int          fail_cnt = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;

  // Inserts an empty slot at pos, shifting later entries up.
  function automatic void tbl_open(int pos);
    for (int k = shd_count; k > pos; k--) begin
      shd_start[k] = shd_start[k-1];
      shd_size[k]  = shd_size[k-1];
      shd_free[k]  = shd_free[k-1];
    end
    shd_count++;
  endfunction

  // Removes the slot at pos, shifting later entries down.
  function automatic void tbl_close(int pos);
    for (int k = pos; k + 1 < shd_count; k++) begin
      shd_start[k] = shd_start[k+1];
      shd_size[k]  = shd_size[k+1];
      shd_free[k]  = shd_free[k+1];
    end
    shd_count--;
  endfunction

  // Applies one request to the shadow state and returns the result it gives.
  function automatic rsp_beat_t heap_apply(logic act, logic [15:0] sz, logic [15:0] ad);
    rsp_beat_t r;
    int lim;
    int fin;
    r.payload_addr = '0;
    r.status = ST_OK;
    if (act == ACT_ALLOC) begin
      // First fit over the table, splitting when the leftover exceeds a header.
      for (int i = 0; i < shd_count; i++) begin
        if (shd_free[i] && shd_size[i] >= sz) begin
          if (int'(shd_size[i]) > int'(sz) + HDR && shd_count < NSEG) begin
            tbl_open(i + 1);
            shd_start[i+1] = shd_start[i] + HDR + sz;
            shd_size[i+1]  = shd_size[i] - sz - HDR;
            shd_free[i+1]  = 1'b1;
            shd_size[i]    = sz;
          end
          shd_free[i] = 1'b0;
          r.payload_addr = shd_start[i] + HDR;
          return r;
        end
      end
      // Nothing fits: append at the break pointer if the limit allows.
      lim = (shd_limit > 17'h10000) ? 32'h10000 : int'(shd_limit);
      fin = int'(shd_break) + HDR + int'(sz);
      if (shd_count >= NSEG || fin > lim || int'(shd_break) + HDR >= 32'h10000) begin
        r.status = ST_NOMEM;
        return r;
      end
      shd_start[shd_count] = shd_break[15:0];
      shd_size[shd_count]  = sz;
      shd_free[shd_count]  = 1'b0;
      shd_count++;
      shd_break = fin[16:0];
      r.payload_addr = shd_break[15:0] - sz;
      return r;
    end
    // Free: mark, then one left-to-right merge pass.
    for (int i = 0; i < shd_count; i++) begin
      if (int'(shd_start[i]) + HDR == int'(ad)) begin
        shd_free[i] = 1'b1;
        for (int c = 0; c + 1 < shd_count; c++) begin
          if (shd_free[c] && shd_free[c+1] &&
              int'(shd_start[c]) + HDR + int'(shd_size[c]) == int'(shd_start[c+1])) begin
            shd_size[c] = shd_size[c] + shd_size[c+1] + HDR;
            tbl_close(c + 1);
          end
        end
        return r;
      end
    end
    r.status = ST_UNKNOWN;
    return r;
  endfunction

  // Sends one request beat, sometimes after a random idle gap.
  task automatic send_req(logic act, logic [15:0] sz, logic [15:0] ad, bit typed,
                          rsp_beat_t want);
    rsp_beat_t pred;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.size    <= sz;
    in_ch.address <= ad;
    do @(posedge clk); while (!in_ch.ready);
    pred = heap_apply(act, sz, ad);
    if (act == ACT_ALLOC && pred.status == ST_OK) live_addrs.push_back(pred.payload_addr);
    pending_rsp.push_back(typed ? want : pred);
  endtask

  // Lowers valid and waits until every expected result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Writes the heap limit while the block is idle.
  task automatic write_limit(logic [16:0] v);
    drain();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.heap_limit <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    shd_limit = v;
  endtask

  // Random traffic: mostly small allocates and frees of live blocks, some noise.
  task automatic random_phase(int n);
    logic act;
    logic [15:0] sz;
    logic [15:0] ad;
    int idx;
    rsp_beat_t none;
    none = '{payload_addr: '0, status: ST_OK};
    for (int j = 0; j < n; j++) begin
      act = ($urandom_range(99) < 55) ? ACT_ALLOC : ACT_FREE;
      sz  = 16'($urandom_range(0, 300));
      if ($urandom_range(99) < 8) sz = 16'($urandom);
      ad  = 16'($urandom);
      if (act == ACT_FREE && live_addrs.size() != 0 && $urandom_range(99) < 80) begin
        idx = $urandom_range(live_addrs.size() - 1);
        ad  = live_addrs[idx];
        if ($urandom_range(99) < 75) live_addrs.delete(idx);
      end else if (act == ACT_FREE && $urandom_range(99) < 20) begin
        ad = 16'($urandom_range(0, 1100));
      end
      send_req(act, sz, ad, 1'b0, none);
    end
  endtask

  // Result side: checks each accepted beat and stalls at random.
  always @(posedge clk) begin
    rsp_beat_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result beat: payload_addr=%0d status=%0d",
               out_ch.payload_addr, out_ch.status);
        fail_cnt++;
      end else begin
        w = pending_rsp.pop_front();
        if (out_ch.payload_addr !== w.payload_addr) begin
          $error("payload_addr: expected %0d, got %0d", w.payload_addr, out_ch.payload_addr);
          fail_cnt++;
        end
        if (out_ch.status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, out_ch.status);
          fail_cnt++;
        end
      end
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= rcv_idle_pct);
  end

  // Directed table, walked in order after reset.
  req_row_t dir_rows[] = '{
    '{ACT_ALLOC, 16'd976,   16'd0,     1, 16'd24,    ST_OK},
    '{ACT_ALLOC, 16'd64000, 16'd0,     1, 16'd1048,  ST_OK},
    '{ACT_ALLOC, 16'd440,   16'd0,     1, 16'd65072, ST_OK},
    '{ACT_ALLOC, 16'd0,     16'd0,     1, 16'd0,     ST_NOMEM},
    '{ACT_ALLOC, 16'd65535, 16'd0,     1, 16'd0,     ST_NOMEM},
    '{ACT_FREE,  16'd0,     16'd0,     1, 16'd0,     ST_UNKNOWN},
    '{ACT_FREE,  16'd65535, 16'd65535, 1, 16'd0,     ST_UNKNOWN},
    '{ACT_FREE,  16'd0,     16'd24,    1, 16'd0,     ST_OK},
    '{ACT_FREE,  16'd0,     16'd24,    1, 16'd0,     ST_OK},
    '{ACT_FREE,  16'd0,     16'd1048,  0, 16'd0,     ST_OK},
    '{ACT_FREE,  16'd0,     16'd65072, 0, 16'd0,     ST_OK},
    '{ACT_ALLOC, 16'd100,   16'd0,     0, 16'd0,     ST_OK},
    '{ACT_ALLOC, 16'd1,     16'd0,     0, 16'd0,     ST_OK},
    '{ACT_ALLOC, 16'd200,   16'd0,     0, 16'd0,     ST_OK},
    '{ACT_FREE,  16'd0,     16'd148,   0, 16'd0,     ST_OK},
    '{ACT_FREE,  16'd0,     16'd24,    0, 16'd0,     ST_OK},
    '{ACT_FREE,  16'd0,     16'd173,   0, 16'd0,     ST_OK},
    '{ACT_ALLOC, 16'd0,     16'hFFFF,  0, 16'd0,     ST_OK},
    '{ACT_ALLOC, 16'hAAAA,  16'd0,     0, 16'd0,     ST_OK},
    '{ACT_FREE,  16'h5555,  16'h5555,  0, 16'd0,     ST_OK},
    '{ACT_FREE,  16'd0,     16'hAAAA,  0, 16'd0,     ST_OK}
  };

  // Main sequence: reset, directed rows, then three random phases.
  initial begin
    rsp_beat_t want;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_ALLOC;
    in_ch.size        <= '0;
    in_ch.address     <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.heap_limit <= LIMIT_RESET;
    shd_start = '{default: '0};
    shd_size  = '{default: '0};
    shd_free  = '{default: 1'b0};
    shd_size[0] = 16'(INIT - HDR);
    shd_free[0] = 1'b1;
    shd_count   = 1;
    shd_break   = 17'(INIT);
    shd_limit   = LIMIT_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_limit(17'h10000);
    snd_idle_pct = 19;
    rcv_idle_pct = 80;
    foreach (dir_rows[r]) begin
      want = '{payload_addr: dir_rows[r].want_addr, status: dir_rows[r].want_status};
      send_req(dir_rows[r].action, dir_rows[r].size, dir_rows[r].address,
               dir_rows[r].typed, want);
    end

    write_limit(17'h1FFFF);
    random_phase(RAND_PER_PHASE);
    write_limit(17'd1024);
    snd_idle_pct = 80;
    rcv_idle_pct = 19;
    random_phase(RAND_PER_PHASE);
    write_limit(17'($urandom_range(1024, 65536)));
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_phase(RAND_PER_PHASE);

    drain();
    repeat (300) @(posedge clk);
    if (fail_cnt == 0 && pending_rsp.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #30000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
